// File: rtl/hpid_pkg.sv
// Shared types and constants of the heading PID step.
// Used by hpid_csr, hpid_mul, hpid_div and heading_pid_with_angle_wrap.
package hpid_pkg;

   localparam int HALF_TURN     = 11520;
   localparam int FULL_TURN     = 23040;
   localparam int MS_PER_SECOND = 1000;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int DIV_W         = 42;
   localparam int DIV_DEN_W     = 16;
   localparam int DIV_STEP_BITS = 2;
   localparam int DIV_CYCLES    = DIV_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_PROP_GAIN      = 3'd0,
      REG_INTEG_GAIN     = 3'd1,
      REG_DERIV_GAIN     = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_OUTPUT_LIMIT   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [15:0] prop_gain;
      logic [15:0] integ_gain;
      logic [15:0] deriv_gain;
      logic [30:0] integral_limit;
      logic [14:0] output_limit;
   } cfg_type;

   localparam logic [30:0] INTEGRAL_LIMIT_RESET = 31'h7FFF_FFFF;
   localparam logic [14:0] OUTPUT_LIMIT_RESET   = 15'h7FFF;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [DIV_W-1:0] mag;
      logic [DIV_DEN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic signed [DIV_W-1:0] quot;
   } div_stat_type;

endpackage

// File: rtl/heading_pid_with_angle_wrap.sv
// Heading PID step with angle wrap, clamped integral and clamped drive output.
// One request in on req_*, one drive value out on rsp_*, gains and limits on csr_*.
// Request tdata: target_angle [15:0], measured_angle [31:16], elapsed_ms [47:32].
// Response tdata: drive_value [15:0], two's complement.
// Angles are in 1/64 degree; the error is wrapped into -11520..+11520 before use.
// A request with elapsed_ms of zero goes straight to the done state, returns 0 and
// leaves the integral and the stored error alone.
// Any other request is worked by a sequencer over one shared multiplier and one
// shared two-bit-per-cycle divider: the integral term divides by 1000 and the
// derivative term by elapsed_ms. req_tready is high only while the sequencer is
// idle, so one request is in work at a time.
// The result sits in an output register; the next request is taken and worked
// while it waits, and the sequencer holds its finished value until rsp_tready.
// Reset clears the integral, the stored error and both handshakes, sets the gains
// to zero and both limits to their maximum.
module heading_pid_with_angle_wrap (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [47:0]                      req_tdata,   // target_angle, measured_angle, elapsed_ms
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // drive_value
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hpid_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [hpid_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hpid_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_WRAP, S_MUL_EI, S_INTEG, S_MUL_I, S_LOAD_I, S_DIV_I,
      S_MUL_D, S_MUL_K, S_LOAD_D, S_DIV_D, S_DONE
   } state_type;

   localparam logic signed [16:0] HALF17 = 17'(hpid_pkg::HALF_TURN);
   localparam logic signed [16:0] FULL17 = 17'(hpid_pkg::FULL_TURN);

   hpid_pkg::cfg_type      cfg;
   hpid_pkg::div_cmd_type  div_cmd;
   hpid_pkg::div_stat_type div_stat;

   logic signed [hpid_pkg::MUL_A_W-1:0] mul_a;
   logic signed [hpid_pkg::MUL_B_W-1:0] mul_b;
   logic signed [hpid_pkg::MUL_P_W-1:0] prod;

   state_type          state_ff,    state_in;
   logic               skip_ff,     skip_in;
   logic [15:0]        ms_ff,       ms_in;
   logic signed [16:0] e_ff,        e_in;
   logic signed [31:0] isum_ff,     isum_in;
   logic signed [14:0] prev_ff,     prev_in;
   logic signed [31:0] integ_ff,    integ_in;
   logic signed [23:0] p_ff,        p_in;
   logic signed [31:0] i_ff,        i_in;
   logic signed [33:0] d_ff,        d_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff,  rsp_data_in;

   logic signed [33:0] sum_integ;
   logic signed [33:0] lim34;
   logic signed [41:0] num_i;
   logic signed [41:0] num_d;
   logic signed [15:0] diff;
   logic signed [35:0] total;
   logic signed [35:0] olim36;

   hpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hpid_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   hpid_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   assign sum_integ = 34'(isum_ff) + 34'($signed(prod[32:0]));
   assign lim34     = 34'(cfg.integral_limit);
   assign num_i     = prod[49:8];
   assign num_d     = prod[41:0];
   assign diff      = e_ff[15:0] - 16'(prev_ff);
   assign total     = 36'(p_ff) + 36'(i_ff) + 36'(d_ff);
   assign olim36    = 36'(cfg.output_limit);

   always_comb begin
      state_in     = state_ff;
      skip_in      = skip_ff;
      ms_in        = ms_ff;
      e_in         = e_ff;
      isum_in      = isum_ff;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_cmd      = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ms_in    = req_tdata[47:32];
               skip_in  = (req_tdata[47:32] == 16'd0);
               e_in     = 17'($signed(req_tdata[15:0])) - 17'($signed(req_tdata[31:16]));
               state_in = (req_tdata[47:32] == 16'd0) ? S_DONE : S_WRAP;
            end
         end
         S_WRAP: begin
            if (e_ff > HALF17) begin
               e_in = e_ff - FULL17;
            end else if (e_ff < -HALF17) begin
               e_in = e_ff + FULL17;
            end else begin
               state_in = S_MUL_EI;
            end
         end
         S_MUL_EI: begin
            mul_a    = 33'(e_ff);
            mul_b    = {1'b0, ms_ff};
            state_in = S_INTEG;
         end
         S_INTEG: begin
            if (sum_integ > lim34) begin
               integ_in = lim34[31:0];
            end else if (sum_integ < -lim34) begin
               integ_in = 32'(-lim34);
            end else begin
               integ_in = sum_integ[31:0];
            end
            mul_a    = 33'(e_ff);
            mul_b    = {1'b0, cfg.prop_gain};
            state_in = S_MUL_I;
         end
         S_MUL_I: begin
            p_in     = prod[31:8];
            mul_a    = 33'(integ_ff);
            mul_b    = {1'b0, cfg.integ_gain};
            state_in = S_LOAD_I;
         end
         S_LOAD_I: begin
            div_cmd.start   = 1'b1;
            div_cmd.neg     = num_i[41];
            div_cmd.mag     = num_i[41] ? 42'(-num_i) : num_i;
            div_cmd.divisor = 16'(hpid_pkg::MS_PER_SECOND);
            state_in        = S_DIV_I;
         end
         S_DIV_I: begin
            if (div_stat.done) begin
               i_in     = div_stat.quot[31:0];
               state_in = S_MUL_D;
            end
         end
         S_MUL_D: begin
            mul_a    = 33'(diff);
            mul_b    = {1'b0, cfg.deriv_gain};
            state_in = S_MUL_K;
         end
         S_MUL_K: begin
            mul_a    = prod[32:0];
            mul_b    = 17'(hpid_pkg::MS_PER_SECOND);
            state_in = S_LOAD_D;
         end
         S_LOAD_D: begin
            div_cmd.start   = 1'b1;
            div_cmd.neg     = num_d[41];
            div_cmd.mag     = num_d[41] ? 42'(-num_d) : num_d;
            div_cmd.divisor = ms_ff;
            state_in        = S_DIV_D;
         end
         S_DIV_D: begin
            if (div_stat.done) begin
               d_in     = div_stat.quot[41:8];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (skip_ff) begin
                  rsp_data_in = '0;
               end else begin
                  if (total > olim36) begin
                     rsp_data_in = olim36[15:0];
                  end else if (total < -olim36) begin
                     rsp_data_in = 16'(-olim36);
                  end else begin
                     rsp_data_in = total[15:0];
                  end
                  isum_in = integ_ff;
                  prev_in = e_ff[14:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         isum_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         isum_ff      <= isum_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      skip_ff     <= skip_in;
      ms_ff       <= ms_in;
      e_ff        <= e_in;
      integ_ff    <= integ_in;
      p_ff        <= p_in;
      i_ff        <= i_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_error_wrapped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_EI) |-> (e_ff <= HALF17 && e_ff >= -HALF17))
      else $error("heading error not wrapped into half turn");

   a_skip_path: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[47:32] == 16'd0)
      |=> (state_ff == S_DONE && skip_ff))
      else $error("zero elapsed request did not take the skip path");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_I || state_ff == S_DIV_D) |-> (div_stat.busy || div_stat.done))
      else $error("sequencer waits on an idle divider");

   a_drive_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_data_ff) <= $signed({1'b0, cfg.output_limit})
                     && $signed(rsp_data_ff) >= -$signed({1'b0, cfg.output_limit})))
      else $error("drive value beyond output limit");

endmodule

// File: rtl/hpid_csr.sv
// Configuration registers of the heading PID step, APB-style write and read.
// Depends on hpid_pkg for the register index codes and the cfg_type bundle.
module hpid_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hpid_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [hpid_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hpid_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output hpid_pkg::cfg_type                cfg
);

   hpid_pkg::cfg_type       cfg_ff;
   hpid_pkg::cfg_type       cfg_in;
   hpid_pkg::reg_index_type index;
   logic                    wr_en;

   assign index      = hpid_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            hpid_pkg::REG_PROP_GAIN:      cfg_in.prop_gain      = csr_pwdata[15:0];
            hpid_pkg::REG_INTEG_GAIN:     cfg_in.integ_gain     = csr_pwdata[15:0];
            hpid_pkg::REG_DERIV_GAIN:     cfg_in.deriv_gain     = csr_pwdata[15:0];
            hpid_pkg::REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_pwdata[30:0];
            hpid_pkg::REG_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_pwdata[14:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         hpid_pkg::REG_PROP_GAIN:      csr_prdata = 32'(cfg_ff.prop_gain);
         hpid_pkg::REG_INTEG_GAIN:     csr_prdata = 32'(cfg_ff.integ_gain);
         hpid_pkg::REG_DERIV_GAIN:     csr_prdata = 32'(cfg_ff.deriv_gain);
         hpid_pkg::REG_INTEGRAL_LIMIT: csr_prdata = 32'(cfg_ff.integral_limit);
         hpid_pkg::REG_OUTPUT_LIMIT:   csr_prdata = 32'(cfg_ff.output_limit);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= '0;
         cfg_ff.integ_gain     <= '0;
         cfg_ff.deriv_gain     <= '0;
         cfg_ff.integral_limit <= hpid_pkg::INTEGRAL_LIMIT_RESET;
         cfg_ff.output_limit   <= hpid_pkg::OUTPUT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/hpid_mul.sv
// Shared signed multiplier of the heading PID step, product registered.
// Depends on hpid_pkg for the operand widths.
module hpid_mul (
   input  logic                                 clock,
   input  logic signed [hpid_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [hpid_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [hpid_pkg::MUL_P_W-1:0]  prod_ff
);

   logic signed [hpid_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = hpid_pkg::MUL_P_W'(mul_a) * hpid_pkg::MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/hpid_div.sv
// Shared restoring divider, two quotient bits a cycle, quotient truncated toward zero.
// Depends on hpid_pkg for widths and the div_cmd_type / div_stat_type bundles.
module hpid_div (
   input  logic                   clock,
   input  logic                   reset,
   input  hpid_pkg::div_cmd_type  cmd,
   output hpid_pkg::div_stat_type stat
);

   logic [hpid_pkg::DIV_DEN_W-1:0] rem_ff,  rem_in;
   logic [hpid_pkg::DIV_W-1:0]     quo_ff,  quo_in;
   logic [hpid_pkg::DIV_DEN_W-1:0] den_ff,  den_in;
   logic [hpid_pkg::DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                           neg_ff,  neg_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   always_comb begin
      logic [hpid_pkg::DIV_DEN_W:0]   r_ext;
      logic [hpid_pkg::DIV_DEN_W-1:0] rem_v;
      logic [hpid_pkg::DIV_W-1:0]     quo_v;
      rem_v   = rem_ff;
      quo_v   = quo_ff;
      r_ext   = '0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = '0;
         quo_in  = cmd.mag;
         den_in  = cmd.divisor;
         neg_in  = cmd.neg;
         cnt_in  = hpid_pkg::DIV_CNT_W'(hpid_pkg::DIV_CYCLES - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int k = 0; k < hpid_pkg::DIV_STEP_BITS; k++) begin
            r_ext = {rem_v, quo_v[hpid_pkg::DIV_W-1]};
            quo_v = {quo_v[hpid_pkg::DIV_W-2:0], 1'b0};
            if (r_ext >= {1'b0, den_ff}) begin
               r_ext    = r_ext - {1'b0, den_ff};
               quo_v[0] = 1'b1;
            end
            rem_v = r_ext[hpid_pkg::DIV_DEN_W-1:0];
         end
         rem_in = rem_v;
         quo_in = quo_v;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quot = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

endmodule
